FILE: hdl/orks_pkg.sv
// Shared types, constants and codes for the outlier rejecting Kalman smoother.
// No dependencies; imported by every other module of the block.
package orks_pkg;

  // Window geometry (power of two)
  localparam int WINDOW = 16;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = (IDX_W > 5) ? IDX_W : 5;
  localparam int SUM_W  = 32 + IDX_W;
  localparam int VACC_W = 48 + IDX_W;

  // Divider geometry
  localparam int DIV_NUM_W = SUM_W;
  localparam int DIV_REM_W = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Fixed-point constants, 16 fraction bits: Q1.16 (17-bit) and Q16.16 (32-bit)
  localparam logic [16:0] ONE_Q     = 17'd65536;
  localparam logic [16:0] NOISE_MIN = 17'd7;
  localparam logic [16:0] TENTH_Q   = 17'd6554;
  localparam logic [16:0] GAIN_MIN  = 17'd66;
  localparam logic [31:0] TWO_Q     = 32'd131072;

  // Register reset values
  localparam logic [16:0] BASE_GAIN_RST = 17'd6554;
  localparam logic [31:0] PNOISE_RST    = 32'd66;
  localparam logic [23:0] THRESH_RST    = 24'd131072;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PNOISE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SUM, OP_MEAN, OP_VAR, OP_VACC, OP_SQI, OP_SQRT,
    OP_LIMIT, OP_REJ, OP_FBK, OP_MDIV, OP_MSET, OP_PRED, OP_KDIV,
    OP_KMUL1, OP_KMUL2, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SUM, S_MEAN, S_VAR, S_VACC, S_SQI, S_SQRT, S_LIMIT, S_REJ,
    S_CHK, S_FBK, S_MDIV, S_MWAIT, S_MSET, S_PRED, S_KDIV, S_KWAIT,
    S_KMUL1, S_KMUL2, S_OUT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic kept_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/outlier_rejecting_kalman_smoother_unit.sv
// Outlier rejecting Kalman smoother: one result per sample.
// The sequencer walks: window sum over WINDOW entries, mean, variance, root
// (32 steps), outlier pass over the window, kept-mean division (36 steps, skipped
// in fallback), prediction, gain division (16 steps), update, output register.
// One item at a time; the output register holds a result while the next sample is taken.
// Reset (async, active low) clears the window, estimate and registers to defaults.
module outlier_rejecting_kalman_smoother_unit import orks_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [31:0]          s_axis_tdata_i,   // [31:0] sample
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,   // [31:0] filtered
  output logic                 m_axis_tuser_o,   // [0] fallback_used
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cmd_t               cmd;
  sts_t               sts;
  logic signed [31:0] filtered;

  orks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  orks_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    ($signed(s_axis_tdata_i)),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .filtered_o  (filtered),
    .fallback_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = filtered;
  assign cfg_ready_o    = 1'b1;

endmodule

FILE: hdl/orks_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on orks_pkg.
module orks_div import orks_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_REM_W-1:0] rem_init_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_REM_W-1:0] den_i,
  input  logic [DIV_CNT_W-1:0] iters_i,
  output logic                 busy_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_REM_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_NUM_W-1:0] num_q, num_d, quot_q, quot_d;
  logic [DIV_REM_W:0]   trial;

  // One shift-subtract step
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    quot_d = quot_q;
    trial  = {rem_q, num_q[DIV_NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      rem_d  = rem_init_i;
      den_d  = den_i;
      num_d  = num_i;
      quot_d = '0;
    end else if (busy_q) begin
      num_d = {num_q[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DIV_REM_W'(trial - {1'b0, den_q});
        quot_d = {quot_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DIV_REM_W-1:0];
        quot_d = {quot_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

FILE: hdl/orks_ctrl.sv
// Sequencer of the smoother: walks the window passes, root, divisions, update.
// Depends on orks_pkg.
module orks_ctrl import orks_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [CNT_W-1:0] WIN_LAST  = CNT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.cnt  = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = '0;
          state_d  = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == WIN_LAST) begin
          cnt_d   = '0;
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.op = OP_MEAN;
        state_d  = S_VAR;
      end
      S_VAR: begin
        cmd_o.op = OP_VAR;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == WIN_LAST) begin
          cnt_d   = '0;
          state_d = S_VACC;
        end
      end
      S_VACC: begin
        cmd_o.op = OP_VACC;
        state_d  = S_SQI;
      end
      S_SQI: begin
        cmd_o.op = OP_SQI;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          state_d = S_LIMIT;
        end
      end
      S_LIMIT: begin
        cmd_o.op = OP_LIMIT;
        state_d  = S_REJ;
      end
      S_REJ: begin
        cmd_o.op = OP_REJ;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == WIN_LAST) begin
          cnt_d   = '0;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = sts_i.kept_zero ? S_FBK : S_MDIV;
      end
      S_FBK: begin
        cmd_o.op = OP_FBK;
        state_d  = S_PRED;
      end
      S_MDIV: begin
        cmd_o.op = OP_MDIV;
        state_d  = S_MWAIT;
      end
      S_MWAIT: begin
        if (!sts_i.div_busy) state_d = S_MSET;
      end
      S_MSET: begin
        cmd_o.op = OP_MSET;
        state_d  = S_PRED;
      end
      S_PRED: begin
        cmd_o.op = OP_PRED;
        state_d  = S_KDIV;
      end
      S_KDIV: begin
        cmd_o.op = OP_KDIV;
        state_d  = S_KWAIT;
      end
      S_KWAIT: begin
        if (!sts_i.div_busy) state_d = S_KMUL1;
      end
      S_KMUL1: begin
        cmd_o.op = OP_KMUL1;
        state_d  = S_KMUL2;
      end
      S_KMUL2: begin
        cmd_o.op = OP_KMUL2;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/orks_dp.sv
// Datapath: window store, statistics, root, outlier test, Kalman update, output register.
// Depends on orks_pkg and orks_div.
module orks_dp import orks_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic signed [31:0]   sample_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   filtered_o,
  output logic                 fallback_o
);

  localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

  logic [IDX_W-1:0] idx;
  assign idx = cmd_i.cnt[IDX_W-1:0];

  // Architectural state
  logic signed [31:0] win_q [WINDOW];
  logic [IDX_W-1:0]   wpos_q;
  logic signed [31:0] est_q;
  logic [31:0]        ev_q;
  logic [16:0]        lgain_q;
  logic [31:0]        scale_q;
  logic [16:0]        bgain_q;
  logic [31:0]        pnoise_q;

  // Work registers
  logic signed [SUM_W-1:0] sum_q, ksum_q;
  logic signed [31:0]      mean_q, m_q;
  logic [31:0]             d_q;
  logic [VACC_W-1:0]       vacc_q;
  logic [63:0]             sqn_q;
  logic [35:0]             sqrem_q;
  logic [31:0]             root_q;
  logic [63:0]             limit_q;
  logic [IDX_W:0]          kcnt_q;
  logic [16:0]             r_q, k_q;
  logic [31:0]             p_q;
  logic signed [50:0]      prod_q;
  logic                    fb_q;
  logic                    ovalid_q;
  logic signed [31:0]      ofilt_q;
  logic                    ofb_q;

  // Distance of the addressed entry from the mean
  logic signed [32:0] diff;
  logic [31:0]        adiff;
  always_comb begin
    diff  = 33'(win_q[idx]) - 33'(mean_q);
    adiff = diff[32] ? 32'(-diff) : diff[31:0];
  end

  // Root step
  logic [35:0] sq_t, sq_trial;
  always_comb begin
    sq_t     = {sqrem_q[33:0], sqn_q[63:62]};
    sq_trial = {2'b00, root_q, 2'b01};
  end

  // Outlier test and kept count
  logic keep;
  assign keep = (root_q == '0) || !({16'b0, adiff, 16'b0} > limit_q);

  // Fallback and normal noise
  logic [29:0] fb_prod;
  logic [16:0] fb_r, base_r, pn;
  always_comb begin
    fb_prod = 30'(lgain_q) * 30'(TENTH_Q);
    fb_r    = {3'b0, fb_prod[29:16]};
    if (fb_r < NOISE_MIN) fb_r = NOISE_MIN;
    if (fb_r > TENTH_Q)   fb_r = TENTH_Q;
    base_r = bgain_q;
    if (base_r < GAIN_MIN) base_r = GAIN_MIN;
    if (base_r > ONE_Q)    base_r = ONE_Q;
    pn = (pnoise_q < 32'(NOISE_MIN)) ? NOISE_MIN : 17'd0;
  end

  // Predicted variance
  logic [32:0] p_sum;
  logic [31:0] pn_eff;
  assign pn_eff = (pnoise_q < 32'(NOISE_MIN)) ? 32'(pn) : pnoise_q;
  assign p_sum  = 33'(ev_q) + 33'(pn_eff);

  // Shared divider
  logic                 div_start, div_busy;
  logic [DIV_REM_W-1:0] div_rem, div_den;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_CNT_W-1:0] div_iters;
  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_num   = ksum_q[SUM_W-1] ? DIV_NUM_W'(-ksum_q) : DIV_NUM_W'(ksum_q);
    div_den   = DIV_REM_W'(kcnt_q);
    div_iters = DIV_CNT_W'(DIV_NUM_W);
    if (cmd_i.op == OP_MDIV) begin
      div_start = 1'b1;
    end else if (cmd_i.op == OP_KDIV) begin
      // quotient is below one, so only the fraction bits are developed
      div_start = 1'b1;
      div_rem   = DIV_REM_W'(p_q);
      div_num   = '0;
      div_den   = DIV_REM_W'(33'(p_q) + 33'(r_q));
      div_iters = DIV_CNT_W'(16);
    end
  end

  orks_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem),
    .num_i      (div_num),
    .den_i      (div_den),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Kept mean with sign restored
  logic signed [32:0] kmean;
  always_comb begin
    kmean = ksum_q[SUM_W-1] ? -33'(div_quot) : 33'(div_quot);
  end

  // Estimate update with saturation
  logic signed [34:0] est_sum;
  logic signed [31:0] est_new;
  logic [48:0]        ev_prod;
  always_comb begin
    est_sum = 35'(prod_q >>> 16) + 35'(est_q);
    if (est_sum > 35'sd2147483647)       est_new = 32'sh7fffffff;
    else if (est_sum < -35'sd2147483648) est_new = 32'sh80000000;
    else                                 est_new = est_sum[31:0];
    ev_prod = 49'(ONE_Q - k_q) * 49'(p_q);
  end

  // Window and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
      wpos_q   <= '0;
      est_q    <= '0;
      ev_q     <= 32'(ONE_Q);
      lgain_q  <= BASE_GAIN_RST;
      scale_q  <= 32'(THRESH_RST);
      bgain_q  <= BASE_GAIN_RST;
      pnoise_q <= PNOISE_RST;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_BASE_GAIN: bgain_q  <= cfg_data_i[16:0];
          REG_PNOISE:    pnoise_q <= cfg_data_i;
          REG_THRESH:    scale_q  <= (cfg_data_i[23:0] == '0) ? TWO_Q
                                                              : 32'(cfg_data_i[23:0]);
          default: ;
        endcase
      end
      if (cmd_i.op == OP_LOAD) begin
        win_q[wpos_q] <= sample_i;
        wpos_q        <= wpos_q + 1'b1;
      end
      if (cmd_i.op == OP_FBK && root_q != '0) scale_q <= root_q;
      if (cmd_i.op == OP_KMUL2) begin
        est_q   <= est_new;
        ev_q    <= ev_prod[47:16];
        lgain_q <= k_q;
      end
      if (cmd_i.op == OP_OUT)   ovalid_q <= 1'b1;
      else if (out_ready_i)     ovalid_q <= 1'b0;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sum_q  <= '0;
        vacc_q <= '0;
        ksum_q <= '0;
        kcnt_q <= '0;
      end
      OP_SUM:  sum_q  <= sum_q + SUM_W'(win_q[idx]);
      OP_MEAN: mean_q <= 32'(sum_q / WIN_S);
      OP_VAR: begin
        d_q <= adiff;
        if (idx != '0) vacc_q <= vacc_q + VACC_W'(((64'(d_q) * 64'(d_q)) >> 16));
      end
      OP_VACC: vacc_q <= vacc_q + VACC_W'(((64'(d_q) * 64'(d_q)) >> 16));
      OP_SQI: begin
        sqn_q   <= {vacc_q[VACC_W-1:IDX_W], 16'b0};
        sqrem_q <= '0;
        root_q  <= '0;
      end
      OP_SQRT: begin
        sqn_q <= {sqn_q[61:0], 2'b00};
        if (sq_t >= sq_trial) begin
          sqrem_q <= sq_t - sq_trial;
          root_q  <= {root_q[30:0], 1'b1};
        end else begin
          sqrem_q <= sq_t;
          root_q  <= {root_q[30:0], 1'b0};
        end
      end
      OP_LIMIT: limit_q <= 64'(scale_q) * 64'(root_q);
      OP_REJ: begin
        if (keep) begin
          ksum_q <= ksum_q + SUM_W'(win_q[idx]);
          kcnt_q <= kcnt_q + 1'b1;
        end
      end
      OP_FBK: begin
        m_q  <= mean_q;
        r_q  <= fb_r;
        fb_q <= 1'b1;
      end
      OP_MSET: begin
        m_q  <= kmean[31:0];
        r_q  <= base_r;
        fb_q <= 1'b0;
      end
      OP_PRED: p_q <= p_sum[32] ? 32'hffffffff : p_sum[31:0];
      OP_KMUL1: begin
        k_q    <= div_quot[16:0];
        prod_q <= 51'($signed({1'b0, div_quot[16:0]})) * 51'(33'(m_q) - 33'(est_q));
      end
      OP_OUT: begin
        ofilt_q <= est_q;
        ofb_q   <= fb_q;
      end
      default: ;
    endcase
  end

  assign sts_o.div_busy  = div_busy;
  assign sts_o.kept_zero = (kcnt_q == '0);
  assign sts_o.out_free  = !ovalid_q || out_ready_i;
  assign out_valid_o     = ovalid_q;
  assign filtered_o      = ofilt_q;
  assign fallback_o      = ofb_q;

endmodule
